### rtl/cgm_pkg.sv
// Shared types, widths and scale constants of the Gell-Mann coefficient block.
`default_nettype none

package cgm_pkg;

   localparam int MAX_SIZE_DEFAULT = 8;

   localparam int ELEM_W  = 16;
   localparam int COEF_W  = 18;
   localparam int INDEX_W = 6;
   localparam int SIZE_W  = 4;
   localparam int CSR_W   = 32;
   localparam int ADDR_W  = 3;
   localparam int L_W     = 3;
   localparam int SUM_W   = 20;
   localparam int K_W     = 16;
   localparam int PROD_W  = SUM_W + K_W + 1;

   typedef enum logic [1:0] {
      KIND_SYM,
      KIND_ASYM,
      KIND_DIAG
   } kind_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] re;
      logic signed [ELEM_W-1:0] im;
   } elem_type;

   // Describes one coefficient as it travels down the pipeline.
   typedef struct packed {
      kind_type           kind;
      logic [L_W-1:0]     l;
      logic [INDEX_W-1:0] pos;
      logic               last;
   } tag_type;

   // round(65536 / sqrt((l+1)(l+2))); the entry for l = 0 is also 1/sqrt2.
   function automatic logic [K_W-1:0] inv_root(input logic [L_W-1:0] l);
      logic [K_W-1:0] k;
      case (l)
         3'd0:    k = 16'd46341;
         3'd1:    k = 16'd26755;
         3'd2:    k = 16'd18919;
         3'd3:    k = 16'd14654;
         3'd4:    k = 16'd11965;
         3'd5:    k = 16'd10112;
         default: k = 16'd8758;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

### rtl/cgm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cgm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/cgm_seq.sv
// Burst sequencer: walks the index pairs and the diagonal and issues read addresses.
`default_nettype none

module cgm_seq #(
   parameter int MAX_SIZE = cgm_pkg::MAX_SIZE_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [cgm_pkg::SIZE_W-1:0]          n,
   input  wire logic                                adv,
   output logic                                     active,
   output logic                                     issue,
   output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]     addr_a,
   output logic [$clog2(MAX_SIZE*MAX_SIZE)-1:0]     addr_b,
   output cgm_pkg::tag_type                         tag
);

   import cgm_pkg::*;

   localparam int JW = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
   localparam int AW = $clog2(MAX_SIZE*MAX_SIZE);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_SYM,
      PH_ASYM,
      PH_DIAG
   } phase_type;

   phase_type          phase_ff;
   logic [JW-1:0]      j_ff;
   logic [JW-1:0]      k_ff;
   logic [INDEX_W-1:0] pos_ff;

   logic [SIZE_W-1:0]  nm1;
   logic [SIZE_W-1:0]  jx;
   logic [SIZE_W-1:0]  kx;
   logic [6:0]         nn;
   logic [7:0]         a_lin;
   logic [7:0]         b_lin;
   logic [7:0]         diag_step;

   assign nm1       = n - SIZE_W'(1);
   assign jx        = SIZE_W'(j_ff);
   assign kx        = SIZE_W'(k_ff);
   assign nn        = 7'(n) * 7'(n);
   assign diag_step = 8'(n) + 8'd1;

   always_comb begin
      if (phase_ff == PH_DIAG) begin
         a_lin = 8'(j_ff) * diag_step;
         b_lin = a_lin + diag_step;
      end else begin
         a_lin = 8'(j_ff) * 8'(n) + 8'(k_ff);
         b_lin = 8'(k_ff) * 8'(n) + 8'(j_ff);
      end
   end

   assign active = (phase_ff != PH_IDLE);
   assign issue  = adv && active;
   assign addr_a = a_lin[AW-1:0];
   assign addr_b = b_lin[AW-1:0];

   always_comb begin
      case (phase_ff)
         PH_SYM:  tag.kind = KIND_SYM;
         PH_ASYM: tag.kind = KIND_ASYM;
         default: tag.kind = KIND_DIAG;
      endcase
      tag.l    = L_W'(j_ff);
      tag.pos  = pos_ff;
      tag.last = (7'(pos_ff) == nn - 7'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         j_ff     <= '0;
         k_ff     <= '0;
         pos_ff   <= '0;
      end else if (start) begin
         phase_ff <= PH_SYM;
         j_ff     <= '0;
         k_ff     <= JW'(1);
         pos_ff   <= '0;
      end else if (issue) begin
         pos_ff <= pos_ff + INDEX_W'(1);
         case (phase_ff)
            PH_SYM, PH_ASYM: begin
               if (kx == nm1) begin
                  if (jx + SIZE_W'(2) == n) begin
                     phase_ff <= (phase_ff == PH_SYM) ? PH_ASYM : PH_DIAG;
                     j_ff     <= '0;
                     k_ff     <= JW'(1);
                  end else begin
                     j_ff <= j_ff + JW'(1);
                     k_ff <= JW'(jx + SIZE_W'(2));
                  end
               end else begin
                  k_ff <= k_ff + JW'(1);
               end
            end
            PH_DIAG: begin
               if (jx + SIZE_W'(2) == n) begin
                  phase_ff <= PH_IDLE;
               end else begin
                  j_ff <= j_ff + JW'(1);
               end
            end
            default: begin
               phase_ff <= PH_IDLE;
            end
         endcase
      end
   end

   a_addr_in_matrix: assert property (@(posedge clock) disable iff (reset)
      issue |-> (7'(addr_a) < nn) && (7'(addr_b) < nn))
      else $error("burst read address lies outside the loaded matrix");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (issue && tag.last) |=> (phase_ff == PH_IDLE))
      else $error("burst did not end after its last coefficient");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (phase_ff == PH_IDLE))
      else $error("burst started while another was running");

endmodule

`default_nettype wire

### rtl/cgm_datapath.sv
// Coefficient datapath: combine the two read entries, scale, round and saturate.
`default_nettype none

module cgm_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               adv,
   input  wire logic                               issue,
   input  wire cgm_pkg::tag_type                   tag,
   input  wire logic [2*cgm_pkg::ELEM_W-1:0]       rd_a,
   input  wire logic [2*cgm_pkg::ELEM_W-1:0]       rd_b,
   output logic                                    busy,
   output logic                                    rsp_valid,
   output logic signed [cgm_pkg::COEF_W-1:0]       rsp_coef_real,
   output logic signed [cgm_pkg::COEF_W-1:0]       rsp_coef_imag,
   output logic [cgm_pkg::INDEX_W-1:0]             rsp_coef_index,
   output logic                                    rsp_final_coef
);

   import cgm_pkg::*;

   localparam int SH_W = PROD_W - 16;
   localparam logic signed [SH_W-1:0] OUT_MAX = SH_W'(131071);
   localparam logic signed [SH_W-1:0] OUT_MIN = -SH_W'(131072);

   // Read stage.
   logic                     s1_v_ff;
   tag_type                  s1_tag_ff;
   // Sum stage.
   logic                     s2_v_ff;
   tag_type                  s2_tag_ff;
   logic signed [SUM_W-1:0]  s2_re_ff;
   logic signed [SUM_W-1:0]  s2_im_ff;
   logic [K_W-1:0]           s2_k_ff;
   // Product stage.
   logic                     s3_v_ff;
   tag_type                  s3_tag_ff;
   logic signed [PROD_W-1:0] s3_re_ff;
   logic signed [PROD_W-1:0] s3_im_ff;
   // Output register.
   logic                     out_v_ff;
   tag_type                  out_tag_ff;
   logic signed [COEF_W-1:0] out_re_ff;
   logic signed [COEF_W-1:0] out_im_ff;

   logic signed [SUM_W-1:0]  prefix_re_ff;
   logic signed [SUM_W-1:0]  prefix_im_ff;

   elem_type                 ea;
   elem_type                 eb;
   logic [L_W:0]             lp1;
   logic signed [SUM_W-1:0]  pre_re_in;
   logic signed [SUM_W-1:0]  pre_im_in;
   logic signed [SUM_W-1:0]  sum_re_in;
   logic signed [SUM_W-1:0]  sum_im_in;
   logic signed [COEF_W-1:0] out_re_in;
   logic signed [COEF_W-1:0] out_im_in;

   function automatic logic signed [COEF_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] r;
      logic signed [SH_W-1:0]   s;
      r = p + PROD_W'(32768);
      s = r[PROD_W-1:16];
      if (s > OUT_MAX) begin
         return OUT_MAX[COEF_W-1:0];
      end else if (s < OUT_MIN) begin
         return OUT_MIN[COEF_W-1:0];
      end
      return s[COEF_W-1:0];
   endfunction

   assign ea  = elem_type'(rd_a);
   assign eb  = elem_type'(rd_b);
   assign lp1 = {1'b0, s1_tag_ff.l} + (L_W+1)'(1);

   // The running diagonal sum restarts on the first diagonal coefficient.
   assign pre_re_in = ((s1_tag_ff.l == '0) ? SUM_W'(0) : prefix_re_ff) + SUM_W'(ea.re);
   assign pre_im_in = ((s1_tag_ff.l == '0) ? SUM_W'(0) : prefix_im_ff) + SUM_W'(ea.im);

   always_comb begin
      case (s1_tag_ff.kind)
         KIND_SYM: begin
            sum_re_in = SUM_W'(ea.re) + SUM_W'(eb.re);
            sum_im_in = SUM_W'(ea.im) + SUM_W'(eb.im);
         end
         KIND_ASYM: begin
            sum_re_in = SUM_W'(eb.im) - SUM_W'(ea.im);
            sum_im_in = SUM_W'(ea.re) - SUM_W'(eb.re);
         end
         default: begin
            sum_re_in = pre_re_in - SUM_W'($signed({1'b0, lp1})) * SUM_W'(eb.re);
            sum_im_in = pre_im_in - SUM_W'($signed({1'b0, lp1})) * SUM_W'(eb.im);
         end
      endcase
   end

   assign out_re_in = round_sat(s3_re_ff);
   assign out_im_in = round_sat(s3_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff  <= issue;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         out_v_ff <= s3_v_ff;
      end
      if (adv) begin
         s1_tag_ff  <= tag;
         s2_tag_ff  <= s1_tag_ff;
         s2_re_ff   <= sum_re_in;
         s2_im_ff   <= sum_im_in;
         s2_k_ff    <= (s1_tag_ff.kind == KIND_DIAG) ? inv_root(s1_tag_ff.l) : inv_root('0);
         s3_tag_ff  <= s2_tag_ff;
         s3_re_ff   <= s2_re_ff * $signed({1'b0, s2_k_ff});
         s3_im_ff   <= s2_im_ff * $signed({1'b0, s2_k_ff});
         out_tag_ff <= s3_tag_ff;
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         if (s1_v_ff && s1_tag_ff.kind == KIND_DIAG) begin
            prefix_re_ff <= pre_re_in;
            prefix_im_ff <= pre_im_in;
         end
      end
   end

   assign busy           = s1_v_ff || s2_v_ff || s3_v_ff || out_v_ff;
   assign rsp_valid      = out_v_ff;
   assign rsp_coef_real  = out_re_ff;
   assign rsp_coef_imag  = out_im_ff;
   assign rsp_coef_index = out_tag_ff.pos;
   assign rsp_final_coef = out_tag_ff.last;

endmodule

`default_nettype wire

### rtl/complex_gell_mann_coefficients.sv
// Top level of the generalized Gell-Mann coefficient block.
`default_nettype none

// Loads an n by n complex matrix (n from matrix_size, clamped to 2..MAX_SIZE) one element
// beat per cycle in row-major order, then emits its n*n-1 Gell-Mann coefficients: symmetric,
// then antisymmetric, then diagonal. The matrix sits in two copies of a RAM so that both
// entries a coefficient needs are read in the same cycle; the burst therefore delivers one
// coefficient beat per cycle while rsp_stall does not hold the output, each one passing the
// read, sum, product and output registers. req_stall is held from the last element beat
// until the final coefficient has been taken. Writing matrix_size abandons a partly loaded
// matrix.
module complex_gell_mann_coefficients #(
   parameter int MAX_SIZE = cgm_pkg::MAX_SIZE_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [cgm_pkg::ELEM_W-1:0]   req_elem_real,
   input  wire logic signed [cgm_pkg::ELEM_W-1:0]   req_elem_imag,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [cgm_pkg::COEF_W-1:0]        rsp_coef_real,
   output logic signed [cgm_pkg::COEF_W-1:0]        rsp_coef_imag,
   output logic [cgm_pkg::INDEX_W-1:0]              rsp_coef_index,
   output logic                                     rsp_final_coef,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cgm_pkg::ADDR_W-1:0]          csr_paddr,
   input  wire logic [cgm_pkg::CSR_W-1:0]           csr_pwdata,
   output logic [cgm_pkg::CSR_W-1:0]                csr_prdata,
   output logic                                     csr_pready
);

   import cgm_pkg::*;

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam logic [SIZE_W-1:0] MAX_N = SIZE_W'(MAX_SIZE);
   localparam logic [ADDR_W-1:0] REG_MATRIX_SIZE = '0;

   logic [SIZE_W-1:0] matrix_size_ff;
   logic [CW-1:0]     count_ff;

   logic [SIZE_W-1:0] n_eff;
   logic [6:0]        nn;
   logic              accept;
   logic              last_elem;
   logic              csr_write;
   logic              adv;
   logic              seq_active;
   logic              dp_busy;
   logic              issue;
   logic [AW-1:0]     addr_a;
   logic [AW-1:0]     addr_b;
   tag_type           tag;
   logic [2*ELEM_W-1:0] rd_a;
   logic [2*ELEM_W-1:0] rd_b;
   elem_type          wr_elem;

   always_comb begin
      if (matrix_size_ff < SIZE_W'(2)) begin
         n_eff = SIZE_W'(2);
      end else if (matrix_size_ff > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = matrix_size_ff;
      end
   end

   assign nn        = 7'(n_eff) * 7'(n_eff);
   assign accept    = req_valid && !req_stall;
   assign last_elem = (7'(count_ff) == nn - 7'd1);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = seq_active || dp_busy;
   assign wr_elem   = '{re: req_elem_real, im: req_elem_imag};

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_size_ff <= MAX_N;
         count_ff       <= '0;
      end else if (csr_write && csr_paddr == REG_MATRIX_SIZE) begin
         matrix_size_ff <= csr_pwdata[SIZE_W-1:0];
         count_ff       <= '0;
      end else if (accept) begin
         count_ff <= last_elem ? '0 : count_ff + CW'(1);
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_MATRIX_SIZE) ? CSR_W'(matrix_size_ff) : '0;

   cgm_ram #(
      .WIDTH (2*ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_elem),
      .rd_en   (adv),
      .rd_addr (addr_a),
      .rd_data (rd_a)
   );

   cgm_ram #(
      .WIDTH (2*ELEM_W),
      .DEPTH (DEPTH)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_elem),
      .rd_en   (adv),
      .rd_addr (addr_b),
      .rd_data (rd_b)
   );

   cgm_seq #(
      .MAX_SIZE (MAX_SIZE)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && last_elem),
      .n      (n_eff),
      .adv    (adv),
      .active (seq_active),
      .issue  (issue),
      .addr_a (addr_a),
      .addr_b (addr_b),
      .tag    (tag)
   );

   cgm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .issue          (issue),
      .tag            (tag),
      .rd_a           (rd_a),
      .rd_b           (rd_b),
      .busy           (dp_busy),
      .rsp_valid      (rsp_valid),
      .rsp_coef_real  (rsp_coef_real),
      .rsp_coef_imag  (rsp_coef_imag),
      .rsp_coef_index (rsp_coef_index),
      .rsp_final_coef (rsp_final_coef)
   );

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_elem) |=> req_stall)
      else $error("input not stalled after the last element of a matrix");

endmodule

`default_nettype wire
